// ----- rtl/core/lsbx_pkg.sv -----
// lsbx_pkg: shared types and constants of the lsb stego bit extractor
// depends on nothing; imported by every module of the block
package lsbx_pkg;

   // end mark: this many consecutive all-ones container bytes
   localparam int END_RUN_LENGTH = 8;

   localparam int BUF_BITS  = 72;   // pending bit buffer
   localparam int CNT_W     = 7;    // pending bit count, 0..72
   localparam int POS_W     = 9;    // position count, 0..256
   localparam int RUN_W     = 4;    // all-ones run length
   localparam int MAX_BYTES = 8;    // bytes released by one transaction
   localparam int NBYTES_W  = 4;    // 0..8
   localparam int JOB_BITS  = MAX_BYTES * 8;

   localparam logic [RUN_W:0]    RUN_END     = (RUN_W + 1)'(END_RUN_LENGTH);
   localparam logic [CNT_W-1:0]  BUF_FULL    = CNT_W'(BUF_BITS);
   localparam logic [NBYTES_W-1:0] BYTES_MAX = NBYTES_W'(MAX_BYTES);

   // job queue between front and back
   localparam int JOBQ_DEPTH = 4;
   localparam int JOBQ_PTR_W = 2;
   localparam int JOBQ_CNT_W = 3;
   localparam logic [JOBQ_CNT_W-1:0] JOBQ_FULL = JOBQ_CNT_W'(JOBQ_DEPTH);

   // opcodes of the input transaction
   localparam logic OP_DATA = 1'b0;
   localparam logic OP_END  = 1'b1;

   // packing degrees that carry bits
   localparam logic [7:0] DEGREE_1 = 8'd1;
   localparam logic [7:0] DEGREE_4 = 8'd4;
   localparam logic [7:0] DEGREE_8 = 8'd8;

   localparam logic [7:0] ONES_BYTE = 8'hFF;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_HEADER_SKIP = 1'b0;   // register index, paddr[2]
   localparam logic [7:0] HEADER_SKIP_RESET = 8'd39;

   // one burst of message bytes, oldest byte in the top bits
   typedef struct packed {
      logic [JOB_BITS-1:0] bytes;
      logic [NBYTES_W-1:0] nbytes;
      logic                fin;
   } job_type;

endpackage

// ----- rtl/core/lsbx_front.sv -----
// lsbx_front: accepts container bytes, tracks header, degree and all-ones runs,
// packs bits and hands finished bursts to the job queue; uses lsbx_pkg
module lsbx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              opcode,
   input  logic [7:0]        data_byte,
   input  logic [7:0]        header_skip,
   output logic              job_push,
   output lsbx_pkg::job_type job
);
   import lsbx_pkg::*;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [7:0]          degree_ff, degree_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic [BUF_BITS-1:0] pend_ff, pend_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;

   logic                degree_ok;
   logic [3:0]          nbits;
   logic [7:0]          left_bits;
   logic [BUF_BITS-1:0] keep_mask;
   logic [BUF_BITS+7:0] placed;
   logic [BUF_BITS-1:0] pend_app;
   logic [CNT_W:0]      sum;
   logic [CNT_W-1:0]    cnt_app;
   logic [CNT_W-1:0]    held;
   logic [CNT_W-1:0]    pre_run;
   logic [POS_W-1:0]    skip_ext;
   logic [NBYTES_W-1:0] nb;

   assign skip_ext  = {1'b0, header_skip};
   assign degree_ok = (degree_ff == DEGREE_1) || (degree_ff == DEGREE_4) ||
                      (degree_ff == DEGREE_8);

   // low degree bits, left justified so the first bit sits at bit 7
   always_comb begin
      case (degree_ff)
         DEGREE_1: begin
            nbits     = 4'd1;
            left_bits = {data_byte[0], 7'b0};
            held      = {3'b0, run_ff};
         end
         DEGREE_4: begin
            nbits     = 4'd4;
            left_bits = {data_byte[3:0], 4'b0};
            held      = {1'b0, run_ff, 2'b0};
         end
         DEGREE_8: begin
            nbits     = 4'd8;
            left_bits = data_byte;
            held      = {run_ff, 3'b0};
         end
         default: begin
            nbits     = 4'd0;
            left_bits = 8'd0;
            held      = '0;
         end
      endcase
   end

   // append at the fill point, bits past the buffer end fall away
   assign keep_mask = ~({BUF_BITS{1'b1}} >> cnt_ff);
   assign placed    = {left_bits, {BUF_BITS{1'b0}}} >> cnt_ff;
   assign pend_app  = (pend_ff & keep_mask) | placed[BUF_BITS+7:8];
   assign sum       = {1'b0, cnt_ff} + {{(CNT_W - 3){1'b0}}, nbits};
   assign cnt_app   = (sum > {1'b0, BUF_FULL}) ? BUF_FULL : sum[CNT_W-1:0];
   assign pre_run   = (cnt_ff > held) ? (cnt_ff - held) : '0;

   always_comb begin
      pos_in    = pos_ff;
      degree_in = degree_ff;
      run_in    = run_ff;
      pend_in   = pend_ff;
      cnt_in    = cnt_ff;
      done_in   = done_ff;
      nb        = '0;
      job.bytes = pend_ff[BUF_BITS-1:BUF_BITS-JOB_BITS];
      job.fin   = 1'b0;
      if (accept && !done_ff) begin
         if (opcode == OP_END) begin
            // flush all but a byte that ends exactly at the bit total
            done_in = 1'b1;
            job.fin = 1'b1;
            if (cnt_ff != '0) begin
               nb = NBYTES_W'((cnt_ff - 1'b1) >> 3);
            end
         end else if (pos_ff < skip_ext) begin
            pos_in = pos_ff + 1'b1;
         end else if (pos_ff == skip_ext) begin
            degree_in = data_byte;
            pos_in    = pos_ff + 1'b1;
         end else if (degree_ok) begin
            if (data_byte == ONES_BYTE) begin
               if ({1'b0, run_ff} + 1'b1 >= RUN_END) begin
                  // end mark: drop the run bits, release what came before
                  done_in = 1'b1;
                  job.fin = 1'b1;
                  cnt_in  = pre_run;
                  nb      = (pre_run[CNT_W-1:3] > BYTES_MAX) ? BYTES_MAX
                                                              : pre_run[CNT_W-1:3];
               end else begin
                  run_in  = run_ff + 1'b1;
                  pend_in = pend_app;
                  cnt_in  = cnt_app;
               end
            end else begin
               run_in    = '0;
               nb        = NBYTES_W'((cnt_app - 1'b1) >> 3);
               job.bytes = pend_app[BUF_BITS-1:BUF_BITS-JOB_BITS];
               pend_in   = pend_app << {nb, 3'b0};
               cnt_in    = cnt_app - {nb, 3'b0};
            end
         end
      end
      job.nbytes = nb;
   end

   assign job_push   = (nb != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         degree_ff <= '0;
         run_ff    <= '0;
         cnt_ff    <= '0;
         done_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         degree_ff <= degree_in;
         run_ff    <= run_in;
         cnt_ff    <= cnt_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

// ----- rtl/core/lsbx_jobq.sv -----
// lsbx_jobq: short queue of byte bursts between front and back
// depends on lsbx_pkg for the job type and depth
module lsbx_jobq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lsbx_pkg::job_type job_in,
   input  logic              pop,
   output lsbx_pkg::job_type job_out,
   output logic              full,
   output logic              avail
);
   import lsbx_pkg::*;

   job_type                entry_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_W-1:0]  wr_ff, wr_in;
   logic [JOBQ_PTR_W-1:0]  rd_ff, rd_in;
   logic [JOBQ_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign full    = (cnt_ff == JOBQ_FULL);
   assign avail   = (cnt_ff != '0);
   assign do_push = push && !full;
   assign do_pop  = pop && avail;
   assign job_out = entry_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= job_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= JOBQ_FULL)
      else $error("job queue count beyond depth");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != JOBQ_FULL) |-> (JOBQ_PTR_W'(wr_ff - rd_ff) == JOBQ_PTR_W'(cnt_ff)))
      else $error("job queue pointers disagree with count");

   a_no_lost_push: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("burst pushed into a full job queue");

endmodule

// ----- rtl/core/lsbx_back.sv -----
// lsbx_back: unpacks one burst at a time into single message bytes
// depends on lsbx_pkg; fed by lsbx_jobq
module lsbx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_avail,
   input  lsbx_pkg::job_type job,
   output logic              job_take,
   input  logic              pop,
   output logic              empty,
   output logic [7:0]        text_byte,
   output logic              last_of_run,
   output logic              finished
);
   import lsbx_pkg::*;

   logic                valid_ff, valid_in;
   logic [JOB_BITS-1:0] bytes_ff, bytes_in;
   logic [NBYTES_W-1:0] rem_ff, rem_in;
   logic                fin_ff, fin_in;
   logic                last;

   assign last     = (rem_ff == NBYTES_W'(1));
   assign job_take = job_avail && (!valid_ff || (pop && last));

   always_comb begin
      valid_in = valid_ff;
      bytes_in = bytes_ff;
      rem_in   = rem_ff;
      fin_in   = fin_ff;
      if (valid_ff && pop) begin
         bytes_in = bytes_ff << 8;
         rem_in   = rem_ff - 1'b1;
         if (last) begin
            valid_in = 1'b0;
         end
      end
      if (job_take) begin
         valid_in = 1'b1;
         bytes_in = job.bytes;
         rem_in   = job.nbytes;
         fin_in   = job.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rem_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      fin_ff   <= fin_in;
   end

   assign empty       = !valid_ff;
   assign text_byte   = bytes_ff[JOB_BITS-1:JOB_BITS-8];
   assign last_of_run = last;
   assign finished    = fin_ff;

   a_rem_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rem_ff != '0) && (rem_ff <= BYTES_MAX))
      else $error("live burst with no bytes left");

   a_step: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && pop && !last) |=> valid_ff && (rem_ff == $past(rem_ff) - 1'b1))
      else $error("burst did not advance by one byte");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !pop) |=> valid_ff && $stable(bytes_ff) && $stable(rem_ff))
      else $error("waiting byte changed without a pop");

endmodule

// ----- rtl/core/lsb_stego_bit_extractor_top.sv -----
// lsb_stego_bit_extractor_top: top level with the configuration register
// instantiates lsbx_front, lsbx_jobq and lsbx_back; uses lsbx_pkg

// The block takes one container byte per cycle while full is low and recovers
// the message hidden in its low bits. The front part counts off the header,
// latches the packing degree, packs 1, 4 or 8 bits per byte into a 72-bit
// pending buffer and watches for the all-ones end mark; whenever bytes become
// final it writes one burst of up to eight message bytes into a four-deep job
// queue in the same cycle. The back part unpacks the oldest burst and shows one
// message byte per cycle on the result ports while pop is asserted. A released
// byte is written into the job queue, then loaded into the back part's register
// once that part is free, and shown on the result ports from there. full rises
// only while the job queue holds four bursts, so sustained input runs at one
// transaction per cycle as long as the consumer takes results at least as fast
// as they are released; a single transaction can release eight bytes, and the
// queue soaks up such a burst while the front keeps going. header_skip is
// written through the register port at address 0 and should only change
// while the block is idle. No clearing pass is needed after reset.
module lsb_stego_bit_extractor_top (
   input  logic                            clock,
   input  logic                            reset,
   // input transactions
   input  logic                            push,
   output logic                            full,
   input  logic                            req_opcode,
   input  logic [7:0]                      req_data_byte,
   // result transactions
   output logic                            empty,
   input  logic                            pop,
   output logic [7:0]                      rsp_text_byte,
   output logic                            rsp_last_of_run,
   output logic                            rsp_finished,
   // register port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lsbx_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import lsbx_pkg::*;

   logic       [7:0] skip_ff, skip_in;
   logic             accept;
   logic             csr_write;
   logic             job_push;
   job_type          job_front;
   job_type          job_head;
   logic             job_avail;
   logic             job_take;

   // register port: no wait states, word register selected by paddr[2]
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      skip_in = skip_ff;
      if (csr_write && (paddr[2] == REG_HEADER_SKIP)) begin
         skip_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= HEADER_SKIP_RESET;
      end else begin
         skip_ff <= skip_in;
      end
   end

   // reads of the unused upper register return zero
   assign prdata = (paddr[2] == REG_HEADER_SKIP) ? {24'b0, skip_ff} : 32'b0;

   // a transaction is taken whenever the job queue has room
   assign accept = push && !full;

   lsbx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .opcode      (req_opcode),
      .data_byte   (req_data_byte),
      .header_skip (skip_ff),
      .job_push    (job_push),
      .job         (job_front)
   );

   lsbx_jobq u_jobq (
      .clock   (clock),
      .reset   (reset),
      .push    (job_push),
      .job_in  (job_front),
      .pop     (job_take),
      .job_out (job_head),
      .full    (full),
      .avail   (job_avail)
   );

   lsbx_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_avail   (job_avail),
      .job         (job_head),
      .job_take    (job_take),
      .pop         (pop),
      .empty       (empty),
      .text_byte   (rsp_text_byte),
      .last_of_run (rsp_last_of_run),
      .finished    (rsp_finished)
   );

endmodule
